// ----- rtl/trapezoid_profile_calculator_defines.svh -----
// Assertion macros for the trapezoid profile calculator.
`ifndef TRAPEZOID_PROFILE_CALCULATOR_DEFINES_SVH
`define TRAPEZOID_PROFILE_CALCULATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TPC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tpc assertion failed");
`define TPC_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("tpc forbidden condition");
`else
`define TPC_ASSERT(label, prop)
`define TPC_ASSERT_NEVER(label, expr)
`endif

`endif

// ----- rtl/tpc_pkg.sv -----
// Types and helpers shared by the trapezoid profile calculator.
package tpc_pkg;

    // Fractional bits of the entry and exit speed factors.
    localparam int FACTOR_FRAC_BITS = 16;

    // Magnitude width of the widest division numerator and divisor width.
    localparam int DIV_W = 57;
    localparam int DEN_W = 26;

    typedef struct packed {
        logic [23:0]               cruise_rate;
        logic [FACTOR_FRAC_BITS:0] entry_scale;
        logic [FACTOR_FRAC_BITS:0] exit_scale;
        logic [23:0]               accel_steps_rate;
        logic [30:0]               step_total;
        logic                      block_busy;
    } t_request;

    typedef struct packed {
        logic signed [31:0] accel_until;
        logic signed [31:0] decel_after;
        logic [23:0]        start_rate;
        logic [23:0]        end_rate;
        logic               apply_update;
    } t_result;

    // Information that travels beside the divider chains.
    typedef struct packed {
        logic [30:0] step_total;
        logic        block_busy;
        logic        accel_zero;
        logic        neg_accel;
        logic        neg_decel;
        logic        neg_meet;
        logic [23:0] start_rate;
        logic [23:0] end_rate;
    } t_side;

    function automatic logic [31:0] sat32(input logic signed [59:0] v);
        logic [31:0] r;
        if (v > 60'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -60'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/trapezoid_profile_calculator.sv -----
// Pipeline: a result strobes once its request has passed 4 front stages, 57 division
// cells and 3 finishing stages; the division chains set the depth.
// Throughput: one request per cycle, busy stays low; results cannot be stalled.
// Reset (synchronous, active low) clears the valid pipeline and sets the minimum
// step rate to 120; requests in flight are dropped.
`include "trapezoid_profile_calculator_defines.svh"
module trapezoid_profile_calculator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  tpc_pkg::t_request i_request,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    output logic              o_valid,
    output tpc_pkg::t_result  o_result
);
    import tpc_pkg::*;

    localparam int LAT = DIV_W + 7;
    localparam logic [24:0] ONE = 25'(1) << FACTOR_FRAC_BITS;

    logic [15:0]    r_min_rate;
    logic [LAT-1:0] r_vld;
    logic           accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rate <= 16'd120;
            r_vld      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_rate <= i_cfg_wdata;
            end
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // Stage 1: saturate factors and form the products.
    logic [24:0] fe, fx;
    logic [48:0] r_s1_pe, r_s1_px;
    logic [47:0] r_s1_n2;
    logic [54:0] r_s1_ac;
    logic [23:0] r_s1_a;
    logic [30:0] r_s1_cnt;
    logic        r_s1_busy;

    always_comb begin
        fe = ({8'b0, i_request.entry_scale} > ONE) ? ONE : {8'b0, i_request.entry_scale};
        fx = ({8'b0, i_request.exit_scale} > ONE) ? ONE : {8'b0, i_request.exit_scale};
    end

    always_ff @(posedge i_clk) begin
        r_s1_pe   <= i_request.cruise_rate * fe;
        r_s1_px   <= i_request.cruise_rate * fx;
        r_s1_n2   <= i_request.cruise_rate * i_request.cruise_rate;
        r_s1_ac   <= i_request.accel_steps_rate * i_request.step_total;
        r_s1_a    <= i_request.accel_steps_rate;
        r_s1_cnt  <= i_request.step_total;
        r_s1_busy <= i_request.block_busy;
    end

    // Stage 2: round the rates up and apply the minimum.
    logic [49:0] sum_s, sum_e;
    logic [23:0] raw_s, raw_e;
    logic [23:0] r_s2_s, r_s2_e, r_s2_a;
    logic [47:0] r_s2_n2;
    logic [54:0] r_s2_ac;
    logic [30:0] r_s2_cnt;
    logic        r_s2_busy;

    always_comb begin
        sum_s = 50'(r_s1_pe) + 50'(ONE - 25'd1);
        sum_e = 50'(r_s1_px) + 50'(ONE - 25'd1);
        raw_s = 24'(sum_s >> FACTOR_FRAC_BITS);
        raw_e = 24'(sum_e >> FACTOR_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        r_s2_s    <= (raw_s < {8'b0, r_min_rate}) ? {8'b0, r_min_rate} : raw_s;
        r_s2_e    <= (raw_e < {8'b0, r_min_rate}) ? {8'b0, r_min_rate} : raw_e;
        r_s2_a    <= r_s1_a;
        r_s2_n2   <= r_s1_n2;
        r_s2_ac   <= r_s1_ac;
        r_s2_cnt  <= r_s1_cnt;
        r_s2_busy <= r_s1_busy;
    end

    // Stage 3: squares of the entry and exit rates.
    logic [47:0] r_s3_s2, r_s3_e2, r_s3_n2;
    logic [54:0] r_s3_ac;
    logic [23:0] r_s3_s, r_s3_e, r_s3_a;
    logic [30:0] r_s3_cnt;
    logic        r_s3_busy;

    always_ff @(posedge i_clk) begin
        r_s3_s2   <= r_s2_s * r_s2_s;
        r_s3_e2   <= r_s2_e * r_s2_e;
        r_s3_n2   <= r_s2_n2;
        r_s3_ac   <= r_s2_ac;
        r_s3_s    <= r_s2_s;
        r_s3_e    <= r_s2_e;
        r_s3_a    <= r_s2_a;
        r_s3_cnt  <= r_s2_cnt;
        r_s3_busy <= r_s2_busy;
    end

    // Stage 4: signed numerators split into sign and magnitude.
    logic [48:0]      num_a, num_d;
    logic [57:0]      num_i;
    logic [48:0]      mag_a, mag_d;
    logic [57:0]      mag_i;
    logic [DIV_W-1:0] r_s4_mag_a, r_s4_mag_d, r_s4_mag_i;
    logic [DEN_W-1:0] r_s4_den2, r_s4_den4;
    t_side            r_s4_side;

    always_comb begin
        num_a = {1'b0, r_s3_n2} - {1'b0, r_s3_s2};
        num_d = {1'b0, r_s3_n2} - {1'b0, r_s3_e2};
        num_i = {2'b0, r_s3_ac, 1'b0} - {10'b0, r_s3_s2} + {10'b0, r_s3_e2};
        mag_a = num_a[48] ? (49'd0 - num_a) : num_a;
        mag_d = num_d[48] ? (49'd0 - num_d) : num_d;
        mag_i = num_i[57] ? (58'd0 - num_i) : num_i;
    end

    always_ff @(posedge i_clk) begin
        r_s4_mag_a <= DIV_W'(mag_a);
        r_s4_mag_d <= DIV_W'(mag_d);
        r_s4_mag_i <= mag_i[DIV_W-1:0];
        r_s4_den2  <= DEN_W'({r_s3_a, 1'b0});
        r_s4_den4  <= {r_s3_a, 2'b00};
        r_s4_side  <= '{step_total: r_s3_cnt, block_busy: r_s3_busy,
                        accel_zero: (r_s3_a == 24'd0), neg_accel: num_a[48],
                        neg_decel: num_d[48], neg_meet: num_i[57],
                        start_rate: r_s3_s, end_rate: r_s3_e};
    end

    // Division chains and the side line that keeps pace with them.
    logic [DIV_W-1:0] q_a, q_d, q_i;
    logic [DEN_W-1:0] rm_a, rm_d, rm_i;
    t_side            r_side [0:DIV_W-1];

    tpc_div_chain #(.W(DIV_W), .D(DEN_W)) u_div_accel (
        .i_clk (i_clk), .i_num (r_s4_mag_a), .i_den (r_s4_den2), .o_quo (q_a), .o_rem (rm_a)
    );
    tpc_div_chain #(.W(DIV_W), .D(DEN_W)) u_div_decel (
        .i_clk (i_clk), .i_num (r_s4_mag_d), .i_den (r_s4_den2), .o_quo (q_d), .o_rem (rm_d)
    );
    tpc_div_chain #(.W(DIV_W), .D(DEN_W)) u_div_meet (
        .i_clk (i_clk), .i_num (r_s4_mag_i), .i_den (r_s4_den4), .o_quo (q_i), .o_rem (rm_i)
    );

    always_ff @(posedge i_clk) begin
        r_side[0] <= r_s4_side;
        for (int k = 1; k < DIV_W; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // Finish 1: apply rounding direction to the magnitudes.
    t_side              sd;
    logic [58:0]        qa_x, qd_x, qi_x;
    logic signed [58:0] r_s5_acc, r_s5_dec, r_s5_meet;
    t_side              r_s5_side;

    always_comb begin
        sd   = r_side[DIV_W-1];
        qa_x = 59'(q_a);
        qd_x = 59'(q_d);
        qi_x = 59'(q_i);
    end

    always_ff @(posedge i_clk) begin
        // Ceiling for the ramp-up and meeting point, floor for the ramp-down.
        if (sd.accel_zero) begin
            r_s5_acc  <= '0;
            r_s5_dec  <= '0;
            r_s5_meet <= '0;
        end else begin
            r_s5_acc  <= sd.neg_accel ? $signed(59'd0 - qa_x)
                                      : $signed(qa_x + 59'(rm_a != '0));
            r_s5_dec  <= sd.neg_decel ? $signed(59'd0 - qd_x - 59'(rm_d != '0))
                                      : $signed(qd_x);
            r_s5_meet <= sd.neg_meet ? $signed(59'd0 - qi_x)
                                     : $signed(qi_x + 59'(rm_i != '0));
        end
        r_s5_side <= sd;
    end

    // Finish 2: plateau length, clamped meeting point.
    logic signed [59:0] cnt_s, acc_s, dec_s, pla;
    logic signed [59:0] r_s6_acc, r_s6_after;
    logic [30:0]        r_s6_meet;
    logic               r_s6_no_plateau;
    t_side              r_s6_side;

    always_comb begin
        cnt_s = $signed({29'b0, r_s5_side.step_total});
        acc_s = 60'(r_s5_acc);
        dec_s = 60'(r_s5_dec);
        pla   = cnt_s - acc_s - dec_s;
    end

    always_ff @(posedge i_clk) begin
        r_s6_acc        <= acc_s;
        r_s6_after      <= cnt_s - dec_s;
        r_s6_no_plateau <= pla[59];
        if (r_s5_meet[58]) begin
            r_s6_meet <= '0;
        end else if (r_s5_meet > $signed({28'b0, r_s5_side.step_total})) begin
            r_s6_meet <= r_s5_side.step_total;
        end else begin
            r_s6_meet <= r_s5_meet[30:0];
        end
        r_s6_side <= r_s5_side;
    end

    // Finish 3: select and saturate into the result register.
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (r_s6_no_plateau) begin
            r_out.accel_until <= $signed({1'b0, r_s6_meet});
            r_out.decel_after <= $signed({1'b0, r_s6_meet});
        end else begin
            r_out.accel_until <= $signed(sat32(r_s6_acc));
            r_out.decel_after <= $signed(sat32(r_s6_after));
        end
        r_out.start_rate   <= r_s6_side.start_rate;
        r_out.end_rate     <= r_s6_side.end_rate;
        r_out.apply_update <= ~r_s6_side.block_busy;
    end

    assign o_valid  = r_vld[LAT-1];
    assign o_result = r_out;

    `TPC_ASSERT(a_latency, accept |-> ##64 o_valid)
    `TPC_ASSERT(a_start_min, o_valid |-> (o_result.start_rate >= {8'b0, r_min_rate}))
    `TPC_ASSERT(a_order, o_valid |-> (o_result.decel_after >= o_result.accel_until))
    `TPC_ASSERT_NEVER(a_busy_high, busy)
endmodule

// ----- rtl/tpc_div_cell.sv -----
// One restoring division step: produces one quotient bit per cycle.
module tpc_div_cell #(
    parameter int W = 57,
    parameter int D = 26
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_quo,
    input  logic [D-1:0] i_rem,
    input  logic [D-1:0] i_den,
    output logic [W-1:0] o_num,
    output logic [W-1:0] o_quo,
    output logic [D-1:0] o_rem,
    output logic [D-1:0] o_den
);
    logic [W-1:0] r_num, r_quo;
    logic [D-1:0] r_rem, r_den;
    logic [D:0]   trial, diff;
    logic         fits;

    always_comb begin
        trial = {i_rem, i_num[W-1]};
        diff  = trial - {1'b0, i_den};
        fits  = trial >= {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        r_num <= {i_num[W-2:0], 1'b0};
        r_quo <= {i_quo[W-2:0], fits};
        r_rem <= fits ? diff[D-1:0] : trial[D-1:0];
        r_den <= i_den;
    end

    assign o_num = r_num;
    assign o_quo = r_quo;
    assign o_rem = r_rem;
    assign o_den = r_den;
endmodule

// ----- rtl/tpc_div_chain.sv -----
// Row of division cells; each request moves one cell down per cycle.
module tpc_div_chain #(
    parameter int W = 57,
    parameter int D = 26
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_num,
    input  logic [D-1:0] i_den,
    output logic [W-1:0] o_quo,
    output logic [D-1:0] o_rem
);
    logic [W-1:0] w_num [0:W];
    logic [W-1:0] w_quo [0:W];
    logic [D-1:0] w_rem [0:W];
    logic [D-1:0] w_den [0:W];

    assign w_num[0] = i_num;
    assign w_quo[0] = '0;
    assign w_rem[0] = '0;
    assign w_den[0] = i_den;

    for (genvar g = 0; g < W; g++) begin : g_cell
        tpc_div_cell #(.W(W), .D(D)) u_cell (
            .i_clk (i_clk),
            .i_num (w_num[g]),
            .i_quo (w_quo[g]),
            .i_rem (w_rem[g]),
            .i_den (w_den[g]),
            .o_num (w_num[g+1]),
            .o_quo (w_quo[g+1]),
            .o_rem (w_rem[g+1]),
            .o_den (w_den[g+1])
        );
    end

    assign o_quo = w_quo[W];
    assign o_rem = w_rem[W];
endmodule
